[hdl/i2cms_pkg.sv]
package i2cms_pkg;

    localparam int unsigned APB_AW = 4;

    typedef enum logic [15:0] {
        PH_IDLE = 16'b0000_0000_0000_0001,
        PH_ST1  = 16'b0000_0000_0000_0010,
        PH_ST2  = 16'b0000_0000_0000_0100,
        PH_SP1  = 16'b0000_0000_0000_1000,
        PH_SP2  = 16'b0000_0000_0001_0000,
        PH_SP3  = 16'b0000_0000_0010_0000,
        PH_WR0  = 16'b0000_0000_0100_0000,
        PH_WR1  = 16'b0000_0000_1000_0000,
        PH_WR2  = 16'b0000_0001_0000_0000,
        PH_AK1  = 16'b0000_0010_0000_0000,
        PH_AK2  = 16'b0000_0100_0000_0000,
        PH_AK3  = 16'b0000_1000_0000_0000,
        PH_RD0  = 16'b0001_0000_0000_0000,
        PH_RD1  = 16'b0010_0000_0000_0000,
        PH_KG1  = 16'b0100_0000_0000_0000,
        PH_KG2  = 16'b1000_0000_0000_0000
    } phase_t;

    localparam logic [2:0] FUNC_NONE     = 3'd0;
    localparam logic [2:0] FUNC_START    = 3'd1;
    localparam logic [2:0] FUNC_STOP     = 3'd2;
    localparam logic [2:0] FUNC_WRITE    = 3'd3;
    localparam logic [2:0] FUNC_READ_ACK = 3'd4;
    localparam logic [2:0] FUNC_READ_NAK = 3'd5;
    localparam logic [2:0] FUNC_WAIT_ACK = 3'd6;

    localparam logic [1:0] REG_LONG_PHASE  = 2'd0;
    localparam logic [1:0] REG_WRITE_PHASE = 2'd1;
    localparam logic [1:0] REG_READ_PHASE  = 2'd2;
    localparam logic [1:0] REG_ACK_TIMEOUT = 2'd3;

    localparam logic [15:0] RST_LONG_PHASE  = 16'd100;
    localparam logic [15:0] RST_WRITE_PHASE = 16'd10;
    localparam logic [15:0] RST_READ_PHASE  = 16'd50;
    localparam logic [15:0] RST_ACK_TIMEOUT = 16'd250;

    typedef struct packed {
        logic [15:0] long_phase_ticks;
        logic [15:0] write_phase_ticks;
        logic [15:0] read_phase_ticks;
        logic [15:0] ack_timeout_ticks;
    } cfg_t;

    typedef struct packed {
        logic       scl;
        logic       sda;
        logic       busy;
        logic [7:0] rx_byte;
        logic       rx_valid;
        logic       ack_fail;
        logic       done;
    } res_t;

endpackage

[hdl/i2c_master_bit_sequencer_core.sv]
// An accepted tick request is loaded into the input register, then into the result
// register once that register is empty or out_ready takes its result. The line state
// advances once per tick; one tick request per clock cycle unless out_ready stalls.
// Reset (rst_n low, asynchronous): sequencer idle with SCL and SDA released high,
// registers back to their defaults, both pipeline registers empty.
module i2c_master_bit_sequencer_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [2:0]                      func,
    input  logic [7:0]                      data_byte,
    input  logic                            sda_level,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            scl_out,
    output logic                            sda_out,
    output logic                            busy_res,
    output logic [7:0]                      rx_byte,
    output logic                            rx_valid,
    output logic                            ack_fail,
    output logic                            done_res,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [i2cms_pkg::APB_AW-1:0]    paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import i2cms_pkg::*;

    cfg_t       cfg;
    res_t       res;
    res_t       out_res_reg;
    logic       out_valid_reg;
    logic       s1_valid_reg;
    logic [2:0] s1_func_reg;
    logic [7:0] s1_data_reg;
    logic       s1_sda_reg;
    logic       advance;
    logic       accept;

    i2cms_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    i2cms_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .func      (s1_func_reg),
        .data_byte (s1_data_reg),
        .sda_level (s1_sda_reg),
        .cfg       (cfg),
        .res       (res)
    );

    assign advance  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || advance;
    assign accept   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_func_reg <= func;
            s1_data_reg <= data_byte;
            s1_sda_reg  <= sda_level;
        end
        if (advance)
        begin
            out_res_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign scl_out   = out_res_reg.scl;
    assign sda_out   = out_res_reg.sda;
    assign busy_res  = out_res_reg.busy;
    assign rx_byte   = out_res_reg.rx_byte;
    assign rx_valid  = out_res_reg.rx_valid;
    assign ack_fail  = out_res_reg.ack_fail;
    assign done_res  = out_res_reg.done;

`ifndef ASSERT_OFF
    a_advance_fills: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("stepped request did not reach the result register");

    a_fail_ends_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_res_reg.ack_fail) |-> (out_res_reg.done && !out_res_reg.busy))
        else $error("ack failure reported outside a completed stop");

    a_read_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_res_reg.rx_valid) |->
            (out_res_reg.done && !out_res_reg.scl && !out_res_reg.busy))
        else $error("read completion with SCL high or still busy");
`endif

endmodule

[hdl/i2cms_regs.sv]
module i2cms_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [i2cms_pkg::APB_AW-1:0]    paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    output i2cms_pkg::cfg_t                 cfg
);
    import i2cms_pkg::*;

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [1:0] reg_idx;
    logic [15:0] rd_val;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.long_phase_ticks  <= RST_LONG_PHASE;
            cfg_reg.write_phase_ticks <= RST_WRITE_PHASE;
            cfg_reg.read_phase_ticks  <= RST_READ_PHASE;
            cfg_reg.ack_timeout_ticks <= RST_ACK_TIMEOUT;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_LONG_PHASE:  cfg_reg.long_phase_ticks  <= pwdata[15:0];
                REG_WRITE_PHASE: cfg_reg.write_phase_ticks <= pwdata[15:0];
                REG_READ_PHASE:  cfg_reg.read_phase_ticks  <= pwdata[15:0];
                REG_ACK_TIMEOUT: cfg_reg.ack_timeout_ticks <= pwdata[15:0];
                default:         cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_LONG_PHASE:  rd_val = cfg_reg.long_phase_ticks;
            REG_WRITE_PHASE: rd_val = cfg_reg.write_phase_ticks;
            REG_READ_PHASE:  rd_val = cfg_reg.read_phase_ticks;
            REG_ACK_TIMEOUT: rd_val = cfg_reg.ack_timeout_ticks;
            default:         rd_val = 16'd0;
        endcase
    end

    assign prdata = {16'd0, rd_val};
    assign cfg    = cfg_reg;

endmodule

[hdl/i2cms_seq.sv]
module i2cms_seq (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            step,
    input  logic [2:0]      func,
    input  logic [7:0]      data_byte,
    input  logic            sda_level,
    input  i2cms_pkg::cfg_t cfg,
    output i2cms_pkg::res_t res
);
    import i2cms_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [15:0] tick_reg, tick_next;
    logic [3:0]  bit_reg, bit_next;
    logic [7:0]  shift_reg, shift_next;
    logic [15:0] poll_reg, poll_next;
    logic        scl_reg, scl_next;
    logic        sda_reg, sda_next;
    logic        send_ack_reg, send_ack_next;
    logic        fail_reg, fail_next;
    logic [7:0]  rx_last_reg, rx_last_next;

    logic [15:0] len_raw;
    logic [16:0] len;
    logic [16:0] tick_inc;
    logic [3:0]  bit_inc;
    logic [7:0]  shift_sh;
    logic        done, rxv, fail;

    always_comb
    begin
        case (phase_reg)
            PH_WR0, PH_WR1, PH_WR2: len_raw = cfg.write_phase_ticks;
            PH_RD0, PH_RD1:         len_raw = cfg.read_phase_ticks;
            default:                len_raw = cfg.long_phase_ticks;
        endcase
    end

    // zero length phase lasts one tick
    assign len      = (len_raw == 16'd0) ? 17'd1 : {1'b0, len_raw};
    assign tick_inc = {1'b0, tick_reg} + 17'd1;
    assign bit_inc  = bit_reg + 4'd1;
    assign shift_sh = {shift_reg[6:0], 1'b0};

    always_comb
    begin
        phase_next    = phase_reg;
        tick_next     = tick_reg;
        bit_next      = bit_reg;
        shift_next    = shift_reg;
        poll_next     = poll_reg;
        scl_next      = scl_reg;
        sda_next      = sda_reg;
        send_ack_next = send_ack_reg;
        fail_next     = fail_reg;
        rx_last_next  = rx_last_reg;
        done          = 1'b0;
        rxv           = 1'b0;
        fail          = 1'b0;

        if (phase_reg == PH_IDLE)
        begin
            tick_next = 16'd0;
            case (func)
                FUNC_START:
                begin
                    sda_next   = 1'b1;
                    scl_next   = 1'b1;
                    phase_next = PH_ST1;
                end
                FUNC_STOP:
                begin
                    scl_next   = 1'b0;
                    sda_next   = 1'b0;
                    phase_next = PH_SP1;
                end
                FUNC_WRITE:
                begin
                    shift_next = data_byte;
                    bit_next   = 4'd0;
                    scl_next   = 1'b0;
                    sda_next   = data_byte[7];
                    phase_next = PH_WR0;
                end
                FUNC_READ_ACK, FUNC_READ_NAK:
                begin
                    send_ack_next = (func == FUNC_READ_ACK);
                    shift_next    = 8'd0;
                    bit_next      = 4'd0;
                    scl_next      = 1'b0;
                    sda_next      = 1'b1;
                    phase_next    = PH_RD0;
                end
                FUNC_WAIT_ACK:
                begin
                    sda_next   = 1'b1;
                    phase_next = PH_AK1;
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
        else if (phase_reg == PH_AK3)
        begin
            if (!sda_level)
            begin
                scl_next   = 1'b0;
                phase_next = PH_IDLE;
                done       = 1'b1;
            end
            else if (poll_reg >= cfg.ack_timeout_ticks)
            begin
                // timeout: flag it and run a stop
                fail_next  = 1'b1;
                scl_next   = 1'b0;
                sda_next   = 1'b0;
                phase_next = PH_SP1;
                tick_next  = 16'd0;
            end
            else
            begin
                poll_next = poll_reg + 16'd1;
            end
        end
        else
        begin
            tick_next = tick_inc[15:0];
            if (tick_inc >= len)
            begin
                tick_next = 16'd0;
                case (phase_reg)
                    PH_ST1:
                    begin
                        sda_next   = 1'b0;
                        phase_next = PH_ST2;
                    end
                    PH_ST2:
                    begin
                        scl_next   = 1'b0;
                        phase_next = PH_IDLE;
                        done       = 1'b1;
                    end
                    PH_SP1:
                    begin
                        scl_next   = 1'b1;
                        phase_next = PH_SP2;
                    end
                    PH_SP2:
                    begin
                        sda_next   = 1'b1;
                        phase_next = PH_SP3;
                    end
                    PH_SP3:
                    begin
                        phase_next = PH_IDLE;
                        done       = 1'b1;
                        fail       = fail_reg;
                        fail_next  = 1'b0;
                    end
                    PH_WR0:
                    begin
                        scl_next   = 1'b1;
                        phase_next = PH_WR1;
                    end
                    PH_WR1:
                    begin
                        scl_next   = 1'b0;
                        phase_next = PH_WR2;
                    end
                    PH_WR2:
                    begin
                        bit_next   = bit_inc;
                        shift_next = shift_sh;
                        if (bit_inc >= 4'd8)
                        begin
                            phase_next = PH_IDLE;
                            done       = 1'b1;
                        end
                        else
                        begin
                            sda_next   = shift_sh[7];
                            phase_next = PH_WR0;
                        end
                    end
                    PH_AK1:
                    begin
                        scl_next   = 1'b1;
                        phase_next = PH_AK2;
                    end
                    PH_AK2:
                    begin
                        poll_next  = 16'd0;
                        phase_next = PH_AK3;
                    end
                    PH_RD0:
                    begin
                        scl_next   = 1'b1;
                        phase_next = PH_RD1;
                    end
                    PH_RD1:
                    begin
                        shift_next = {shift_reg[6:0], sda_level};
                        bit_next   = bit_inc;
                        scl_next   = 1'b0;
                        if (bit_inc >= 4'd8)
                        begin
                            sda_next   = !send_ack_reg;
                            phase_next = PH_KG1;
                        end
                        else
                        begin
                            phase_next = PH_RD0;
                        end
                    end
                    PH_KG1:
                    begin
                        scl_next   = 1'b1;
                        phase_next = PH_KG2;
                    end
                    PH_KG2:
                    begin
                        scl_next     = 1'b0;
                        phase_next   = PH_IDLE;
                        rx_last_next = shift_reg;
                        done         = 1'b1;
                        rxv          = 1'b1;
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            tick_reg     <= 16'd0;
            bit_reg      <= 4'd0;
            shift_reg    <= 8'd0;
            poll_reg     <= 16'd0;
            scl_reg      <= 1'b1;
            sda_reg      <= 1'b1;
            send_ack_reg <= 1'b0;
            fail_reg     <= 1'b0;
            rx_last_reg  <= 8'd0;
        end
        else if (step)
        begin
            phase_reg    <= phase_next;
            tick_reg     <= tick_next;
            bit_reg      <= bit_next;
            shift_reg    <= shift_next;
            poll_reg     <= poll_next;
            scl_reg      <= scl_next;
            sda_reg      <= sda_next;
            send_ack_reg <= send_ack_next;
            fail_reg     <= fail_next;
            rx_last_reg  <= rx_last_next;
        end
    end

    assign res.scl      = scl_next;
    assign res.sda      = sda_next;
    assign res.busy     = (phase_next != PH_IDLE);
    assign res.rx_byte  = rx_last_next;
    assign res.rx_valid = rxv;
    assign res.ack_fail = fail;
    assign res.done     = done;

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import i2cms_pkg::*;

    localparam logic [2:0] FUNC_UNUSED   = 3'd7;
    localparam int unsigned STALL_LIMIT  = 4000;
    localparam int unsigned DRAIN_CYCLES = 10;
    localparam int unsigned RANDOM_TICKS = 300;
    localparam int unsigned EPOCH_TICKS  = 100;
    localparam int          HOLD_FOREVER = 70000;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic [2:0]          func;
    logic [7:0]          data_byte;
    logic                sda_level;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic                scl_out;
    logic                sda_out;
    logic                busy_res;
    logic [7:0]          rx_byte;
    logic                rx_valid;
    logic                ack_fail;
    logic                done_res;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [APB_AW-1:0]   paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    // bus model state
    cfg_t                bus_cfg;
    phase_t              bus_phase;
    logic [16:0]         bus_ticks;
    logic [15:0]         bus_polls;
    logic [3:0]          bus_bits;
    logic [7:0]          bus_shift;
    logic [7:0]          bus_rx_last;
    logic                bus_scl;
    logic                bus_sda;
    logic                bus_ack_flag;
    logic                bus_fail_pend;

    res_t                line_exp_q[$];
    int unsigned         err_count = 0;
    int unsigned         stall_cycles = 0;
    int unsigned         ticks_sent = 0;
    bit                  no_gaps = 1'b0;

    i2c_master_bit_sequencer_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .func      (func),
        .data_byte (data_byte),
        .sda_level (sda_level),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .scl_out   (scl_out),
        .sda_out   (sda_out),
        .busy_res  (busy_res),
        .rx_byte   (rx_byte),
        .rx_valid  (rx_valid),
        .ack_fail  (ack_fail),
        .done_res  (done_res),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic void reset_bus_model();
        bus_cfg.long_phase_ticks  = RST_LONG_PHASE;
        bus_cfg.write_phase_ticks = RST_WRITE_PHASE;
        bus_cfg.read_phase_ticks  = RST_READ_PHASE;
        bus_cfg.ack_timeout_ticks = RST_ACK_TIMEOUT;
        bus_phase     = PH_IDLE;
        bus_ticks     = '0;
        bus_polls     = '0;
        bus_bits      = '0;
        bus_shift     = '0;
        bus_rx_last   = '0;
        bus_scl       = 1'b1;
        bus_sda       = 1'b1;
        bus_ack_flag  = 1'b0;
        bus_fail_pend = 1'b0;
    endfunction

    // zero length counts as one tick
    function automatic logic [16:0] phase_ticks(phase_t p);
        logic [15:0] len;
        case (p)
            PH_WR0, PH_WR1, PH_WR2: len = bus_cfg.write_phase_ticks;
            PH_RD0, PH_RD1:         len = bus_cfg.read_phase_ticks;
            default:                len = bus_cfg.long_phase_ticks;
        endcase
        return (len == 16'd0) ? 17'd1 : {1'b0, len};
    endfunction

    function automatic void enter_stop();
        bus_scl   = 1'b0;
        bus_sda   = 1'b0;
        bus_phase = PH_SP1;
        bus_ticks = '0;
    endfunction

    function automatic res_t predict_bus_tick(logic [2:0] f, logic [7:0] d, logic s);
        res_t r;
        logic done;
        logic rxv;
        logic fail;
        done = 1'b0;
        rxv  = 1'b0;
        fail = 1'b0;
        if (bus_phase == PH_IDLE)
        begin
            bus_ticks = '0;
            case (f)
                FUNC_START:
                begin
                    bus_sda   = 1'b1;
                    bus_scl   = 1'b1;
                    bus_phase = PH_ST1;
                end
                FUNC_STOP: enter_stop();
                FUNC_WRITE:
                begin
                    bus_shift = d;
                    bus_bits  = '0;
                    bus_scl   = 1'b0;
                    bus_sda   = d[7];
                    bus_phase = PH_WR0;
                end
                FUNC_READ_ACK, FUNC_READ_NAK:
                begin
                    bus_ack_flag = (f == FUNC_READ_ACK);
                    bus_shift    = '0;
                    bus_bits     = '0;
                    bus_scl      = 1'b0;
                    bus_sda      = 1'b1;
                    bus_phase    = PH_RD0;
                end
                FUNC_WAIT_ACK:
                begin
                    bus_sda   = 1'b1;
                    bus_phase = PH_AK1;
                end
                default: ;
            endcase
        end
        else if (bus_phase == PH_AK3)
        begin
            if (!s)
            begin
                bus_scl   = 1'b0;
                bus_phase = PH_IDLE;
                done      = 1'b1;
            end
            else if (bus_polls >= bus_cfg.ack_timeout_ticks)
            begin
                bus_fail_pend = 1'b1;
                enter_stop();
            end
            else
                bus_polls = bus_polls + 16'd1;
        end
        else
        begin
            bus_ticks = bus_ticks + 17'd1;
            if (bus_ticks >= phase_ticks(bus_phase))
            begin
                bus_ticks = '0;
                case (bus_phase)
                    PH_ST1: begin bus_sda = 1'b0; bus_phase = PH_ST2; end
                    PH_ST2: begin bus_scl = 1'b0; bus_phase = PH_IDLE; done = 1'b1; end
                    PH_SP1: begin bus_scl = 1'b1; bus_phase = PH_SP2; end
                    PH_SP2: begin bus_sda = 1'b1; bus_phase = PH_SP3; end
                    PH_SP3:
                    begin
                        bus_phase     = PH_IDLE;
                        done          = 1'b1;
                        fail          = bus_fail_pend;
                        bus_fail_pend = 1'b0;
                    end
                    PH_WR0: begin bus_scl = 1'b1; bus_phase = PH_WR1; end
                    PH_WR1: begin bus_scl = 1'b0; bus_phase = PH_WR2; end
                    PH_WR2:
                    begin
                        bus_bits  = bus_bits + 4'd1;
                        bus_shift = bus_shift << 1;
                        if (bus_bits >= 4'd8)
                        begin
                            bus_phase = PH_IDLE;
                            done      = 1'b1;
                        end
                        else
                        begin
                            bus_sda   = bus_shift[7];
                            bus_phase = PH_WR0;
                        end
                    end
                    PH_AK1: begin bus_scl = 1'b1; bus_phase = PH_AK2; end
                    PH_AK2: begin bus_polls = '0; bus_phase = PH_AK3; end
                    PH_RD0: begin bus_scl = 1'b1; bus_phase = PH_RD1; end
                    PH_RD1:
                    begin
                        bus_shift = {bus_shift[6:0], s};
                        bus_bits  = bus_bits + 4'd1;
                        bus_scl   = 1'b0;
                        if (bus_bits >= 4'd8)
                        begin
                            bus_sda   = !bus_ack_flag;
                            bus_phase = PH_KG1;
                        end
                        else
                            bus_phase = PH_RD0;
                    end
                    PH_KG1: begin bus_scl = 1'b1; bus_phase = PH_KG2; end
                    PH_KG2:
                    begin
                        bus_scl     = 1'b0;
                        bus_phase   = PH_IDLE;
                        bus_rx_last = bus_shift;
                        done        = 1'b1;
                        rxv         = 1'b1;
                    end
                    default: bus_phase = PH_IDLE;
                endcase
            end
        end
        r.scl      = bus_scl;
        r.sda      = bus_sda;
        r.busy     = (bus_phase != PH_IDLE);
        r.rx_byte  = bus_rx_last;
        r.rx_valid = rxv;
        r.ack_fail = fail;
        r.done     = done;
        return r;
    endfunction

    task automatic send_tick(logic [2:0] f, logic [7:0] d, logic s);
        while (!no_gaps && $urandom_range(0, 99) < 11)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        func      <= f;
        data_byte <= d;
        sda_level <= s;
        in_valid  <= 1'b1;
        do @(posedge clk); while (!in_ready);
        line_exp_q.push_back(predict_bus_tick(f, d, s));
        ticks_sent++;
    endtask

    // during the ack poll, SDA stays high for hold_high polls, then drops
    function automatic logic pick_sda(int hold_high);
        if (bus_phase == PH_AK3)
            return (int'(bus_polls) < hold_high);
        return 1'($urandom_range(0, 1));
    endfunction

    function automatic int ack_hold(int unsigned tmo);
        if ($urandom_range(0, 4) == 0)
            return HOLD_FOREVER;
        return int'($urandom_range(0, tmo));
    endfunction

    // issue one command, then feed ticks (with ignored noise commands) until idle
    task automatic run_command(logic [2:0] f, logic [7:0] d, int hold_high);
        send_tick(f, d, pick_sda(hold_high));
        while (bus_phase != PH_IDLE)
            send_tick(3'($urandom_range(0, 7)), 8'($urandom), pick_sda(hold_high));
    endtask

    task automatic idle_ticks(int unsigned n);
        repeat (n)
            send_tick(($urandom_range(0, 1) == 0) ? FUNC_NONE : FUNC_UNUSED,
                      8'($urandom), 1'($urandom_range(0, 1)));
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        in_valid <= 1'b0;
        while (line_exp_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'h0000, val};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_LONG_PHASE:  bus_cfg.long_phase_ticks  = val;
            REG_WRITE_PHASE: bus_cfg.write_phase_ticks = val;
            REG_READ_PHASE:  bus_cfg.read_phase_ticks  = val;
            REG_ACK_TIMEOUT: bus_cfg.ack_timeout_ticks = val;
            default: ;
        endcase
    endtask

    task automatic check_reg(logic [1:0] idx, logic [15:0] want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== {16'h0000, want})
        begin
            $display("%0t: prdata mismatch, expected %0h, actual %0h",
                     $time, {16'h0000, want}, prdata);
            err_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic configure(logic [15:0] lng, logic [15:0] wr, logic [15:0] rd,
                             logic [15:0] tmo);
        write_reg(REG_LONG_PHASE, lng);
        write_reg(REG_WRITE_PHASE, wr);
        write_reg(REG_READ_PHASE, rd);
        write_reg(REG_ACK_TIMEOUT, tmo);
    endtask

    task automatic test_defaults();
        check_reg(REG_LONG_PHASE, RST_LONG_PHASE);
        check_reg(REG_WRITE_PHASE, RST_WRITE_PHASE);
        check_reg(REG_READ_PHASE, RST_READ_PHASE);
        check_reg(REG_ACK_TIMEOUT, RST_ACK_TIMEOUT);
        idle_ticks(2);
        run_command(FUNC_START, 8'h00, 0);
        run_command(FUNC_WRITE, 8'hA5, 0);
        run_command(FUNC_STOP, 8'h00, 0);
    endtask

    // zero lengths behave as one tick, zero timeout fails on the first high poll
    task automatic test_zero_settings();
        configure(16'd0, 16'd0, 16'd0, 16'd0);
        run_command(FUNC_START, 8'h5A, 0);
        run_command(FUNC_WRITE, 8'h00, 0);
        run_command(FUNC_WAIT_ACK, 8'h00, HOLD_FOREVER);
        run_command(FUNC_WAIT_ACK, 8'hFF, 0);
        run_command(FUNC_READ_NAK, 8'h00, 0);
        run_command(FUNC_STOP, 8'hFF, 0);
        idle_ticks(3);
    endtask

    // timeout boundary: hold equal to the timeout passes, one more fails
    task automatic test_min_settings();
        configure(16'd1, 16'd1, 16'd1, 16'd1);
        run_command(FUNC_START, 8'h00, 0);
        run_command(FUNC_WRITE, 8'h80, 0);
        run_command(FUNC_WAIT_ACK, 8'h00, 1);
        run_command(FUNC_WRITE, 8'h7F, 0);
        run_command(FUNC_WAIT_ACK, 8'h00, 2);
        run_command(FUNC_READ_ACK, 8'h00, 0);
        run_command(FUNC_READ_NAK, 8'h00, 0);
        run_command(FUNC_STOP, 8'h00, 0);
    endtask

    // full-range timeout with a long ack hold, no idling on either side
    task automatic test_max_settings();
        no_gaps = 1'b1;
        configure(16'd1, 16'd1, 16'd1, 16'hFFFF);
        run_command(FUNC_START, 8'h00, 0);
        run_command(FUNC_WAIT_ACK, 8'h00, 300);
        run_command(FUNC_STOP, 8'h00, 0);
        no_gaps = 1'b0;
    endtask

    task automatic bus_transaction(int unsigned tmo);
        run_command(FUNC_START, 8'($urandom), 0);
        run_command(FUNC_WRITE, 8'($urandom), 0);
        run_command(FUNC_WAIT_ACK, 8'($urandom), ack_hold(tmo));
        repeat ($urandom_range(1, 3))
        begin
            case ($urandom_range(0, 2))
                0:
                begin
                    run_command(FUNC_WRITE, 8'($urandom), 0);
                    run_command(FUNC_WAIT_ACK, 8'($urandom), ack_hold(tmo));
                end
                1: run_command(FUNC_READ_ACK, 8'($urandom), 0);
                default: run_command(FUNC_READ_NAK, 8'($urandom), 0);
            endcase
        end
        run_command(FUNC_STOP, 8'($urandom), 0);
    endtask

    task automatic test_random_traffic();
        int unsigned first_tick;
        int unsigned epoch_end;
        int unsigned tmo;
        first_tick = ticks_sent;
        while (ticks_sent - first_tick < RANDOM_TICKS)
        begin
            tmo = $urandom_range(0, 6);
            configure(16'($urandom_range(1, 4)), 16'($urandom_range(1, 3)),
                      16'($urandom_range(1, 3)), 16'(tmo));
            epoch_end = ticks_sent + EPOCH_TICKS;
            while (ticks_sent < epoch_end)
            begin
                if ($urandom_range(0, 99) < 85)
                    bus_transaction(tmo);
                else
                    run_command(3'($urandom_range(0, 7)), 8'($urandom),
                                int'($urandom_range(0, tmo + 2)));
                if ($urandom_range(0, 3) == 0)
                    idle_ticks($urandom_range(1, 3));
            end
        end
    endtask

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            err_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        res_t got;
        res_t want;
        if (rst_n && out_valid && out_ready)
        begin
            got = {scl_out, sda_out, busy_res, rx_byte, rx_valid, ack_fail, done_res};
            if (line_exp_q.size() == 0)
            begin
                $display("%0t: result with no request pending, expected none, actual %0h",
                         $time, got);
                err_count++;
            end
            else
            begin
                want = line_exp_q.pop_front();
                check_field("scl_out", 8'(want.scl), 8'(got.scl));
                check_field("sda_out", 8'(want.sda), 8'(got.sda));
                check_field("busy_res", 8'(want.busy), 8'(got.busy));
                check_field("rx_byte", want.rx_byte, got.rx_byte);
                check_field("rx_valid", 8'(want.rx_valid), 8'(got.rx_valid));
                check_field("ack_fail", 8'(want.ack_fail), 8'(got.ack_fail));
                check_field("done_res", 8'(want.done), 8'(got.done));
            end
        end
    end

    always @(posedge clk)
        out_ready <= no_gaps || ($urandom_range(0, 99) >= 11);

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        reset_bus_model();
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        func      <= FUNC_NONE;
        data_byte <= 8'h00;
        sda_level <= 1'b1;
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        paddr     <= '0;
        pwdata    <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_defaults();
        test_zero_settings();
        test_min_settings();
        test_max_settings();
        test_random_traffic();

        in_valid <= 1'b0;
        while (line_exp_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

[sim.f]
hdl/i2cms_pkg.sv
hdl/i2cms_regs.sv
hdl/i2cms_seq.sv
hdl/i2c_master_bit_sequencer_core.sv
tb/sv/testbench.sv
